/* sv/mbps_pkg.sv */
// Package for the masked byte pattern scanner.
// Holds the register index codes, field widths and the per-cell control struct.
// No dependencies.
package mbps_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int ADDR_W      = 64;
  localparam int LEN_W       = 5;
  localparam int STEP_W      = 5;
  localparam int PHASE_W     = 4;
  localparam int MASK_W      = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LOW    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HIGH   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_COMPARE_MASK   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_ALIGNMENT_STEP = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_REGION_BASE    = 3'd5;

  localparam logic [MASK_W-1:0] COMPARE_MASK_RESET   = 16'hFFFF;
  localparam logic [STEP_W-1:0] ALIGNMENT_STEP_RESET = 5'd1;
  localparam logic [STEP_W-1:0] STEP_TOP             = 5'd16;

  // Control for one window cell: the pattern byte lined up with it, whether
  // it is compared, and whether it holds the first byte of a candidate.
  typedef struct packed {
    logic [7:0] pattern;
    logic       care;
    logic       anchor;
  } cell_ctrl_t;

endpackage

/* sv/mbps_if.sv */
// Stream interfaces of the masked byte pattern scanner.
// Byte channel into the block and match channel out of it; uses mbps_pkg.
interface mbps_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source(output valid, output data_byte, output last_byte, input ready);
  modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

interface mbps_match_if;
  logic                       valid;
  logic                       ready;
  logic                       found;
  logic [mbps_pkg::ADDR_W-1:0] match_address;
  logic                       region_done;

  modport source(output valid, output found, output match_address,
                 output region_done, input ready);
  modport sink(input valid, input found, input match_address,
               input region_done, output ready);
endinterface

/* sv/mbps_cell.sv */
// One cell of the scan window: holds one byte and its alignment flag.
// Uses mbps_pkg::cell_ctrl_t; instantiated in a row by the top level.
module mbps_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 shift,
  input  logic                 clear,
  input  mbps_pkg::cell_ctrl_t ctrl,
  input  logic [7:0]           byte_in,
  input  logic                 flag_in,
  output logic [7:0]           byte_q,
  output logic                 flag_q,
  output logic                 ok
);

  // Judge the byte that enters this cell on the current beat.
  assign ok = (!ctrl.care || (byte_in == ctrl.pattern)) && (!ctrl.anchor || flag_in);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_q <= '0;
      flag_q <= 1'b0;
    end else if (shift) begin
      if (clear) begin
        byte_q <= '0;
        flag_q <= 1'b0;
      end else begin
        byte_q <= byte_in;
        flag_q <= flag_in;
      end
    end
  end

endmodule

/* sv/masked_byte_pattern_scanner.sv */
// Top level of the masked byte pattern scanner.
// Depends on mbps_pkg, the interfaces in mbps_if.sv and the mbps_cell row.
//
// Usage:
//   byte_ch carries one region byte per beat in address order; last_byte marks
//   the final byte of a region. match_ch returns one beat for every byte that
//   completes a match (found = 1, match_address = region base plus the start
//   offset) and one for every last byte (region_done = 1); both may share a
//   beat. Bytes that produce neither give no beat.
//   The configuration port (cfg_we, cfg_index, cfg_data) writes the pattern,
//   length, compare mask, alignment step and region base; write it only while
//   the block is idle.
// Timing:
//   The row of MAX_PATTERN cells compares the whole window against the pattern
//   as each byte enters, so one byte is taken every cycle unless a match_ch
//   stall has filled both stages. A result passes two register stages on its
//   way to match_ch: one for the compare and offset subtract, one for the
//   64-bit base add in the output register.
// Reset and stall:
//   Reset clears the window, offset and phase and loads register defaults
//   (compare mask all ones, step one, others zero). When match_ch stalls, the
//   output register holds its beat and one more result waits in the compare
//   stage; byte_ch stays ready until both are full.
module masked_byte_pattern_scanner #(
  parameter int MAX_PATTERN = 16,
  parameter int OFFSET_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  mbps_byte_if.sink                        byte_ch,
  mbps_match_if.source                     match_ch,
  input  logic                             cfg_we,
  input  logic [mbps_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mbps_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // Configuration registers.
  logic [63:0]                      pattern_low;
  logic [63:0]                      pattern_high;
  logic [mbps_pkg::LEN_W-1:0]       pattern_length;
  logic [mbps_pkg::MASK_W-1:0]      compare_mask;
  logic [mbps_pkg::STEP_W-1:0]      alignment_step;
  logic [mbps_pkg::ADDR_W-1:0]      region_base;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      pattern_length <= '0;
      compare_mask   <= mbps_pkg::COMPARE_MASK_RESET;
      alignment_step <= mbps_pkg::ALIGNMENT_STEP_RESET;
      region_base    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        mbps_pkg::REG_PATTERN_LOW:    pattern_low    <= cfg_data;
        mbps_pkg::REG_PATTERN_HIGH:   pattern_high   <= cfg_data;
        mbps_pkg::REG_PATTERN_LENGTH: pattern_length <= cfg_data[mbps_pkg::LEN_W-1:0];
        mbps_pkg::REG_COMPARE_MASK:   compare_mask   <= cfg_data[mbps_pkg::MASK_W-1:0];
        mbps_pkg::REG_ALIGNMENT_STEP: alignment_step <= cfg_data[mbps_pkg::STEP_W-1:0];
        mbps_pkg::REG_REGION_BASE:    region_base    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective length and step: clamp the length to the row, map a zero step
  // to one and cap the step at sixteen.
  logic [mbps_pkg::LEN_W-1:0]  len_eff;
  logic [mbps_pkg::LEN_W-1:0]  len_m1;
  logic [mbps_pkg::STEP_W-1:0] step_eff;
  logic [127:0]                pattern_all;

  assign len_eff = (pattern_length > mbps_pkg::LEN_W'(MAX_PATTERN)) ?
                   mbps_pkg::LEN_W'(MAX_PATTERN) : pattern_length;
  assign len_m1  = len_eff - mbps_pkg::LEN_W'(1);
  assign step_eff = (alignment_step == '0) ? mbps_pkg::STEP_W'(1) :
                    (alignment_step > mbps_pkg::STEP_TOP) ? mbps_pkg::STEP_TOP :
                    alignment_step;
  assign pattern_all = {pattern_high, pattern_low};

  // Handshake and pipeline control.
  logic byte_acc;
  logic s1_valid;
  logic out_valid;
  logic out_free;
  logic s1_take;

  assign out_free = !out_valid || match_ch.ready;
  assign s1_take  = s1_valid && out_free;
  assign byte_ch.ready = !s1_valid || out_free;
  assign byte_acc = byte_ch.valid && byte_ch.ready;

  // Region position: offset of the current byte and its phase within the step.
  logic [OFFSET_BITS-1:0]       offset;
  logic [mbps_pkg::PHASE_W-1:0] phase;
  logic [mbps_pkg::STEP_W-1:0]  phase_inc;

  assign phase_inc = {1'b0, phase} + mbps_pkg::STEP_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      offset <= '0;
      phase  <= '0;
    end else if (byte_acc) begin
      if (byte_ch.last_byte) begin
        offset <= '0;
        phase  <= '0;
      end else begin
        // Hold the offset once it reaches its top value.
        if (offset != '1) begin
          offset <= offset + OFFSET_BITS'(1);
        end
        phase <= (phase_inc >= step_eff) ? '0 : phase_inc[mbps_pkg::PHASE_W-1:0];
      end
    end
  end

  // Line the pattern up with the window: cell k holds the byte that pattern
  // byte (len - 1 - k) must match; the cell at len - 1 holds the start byte.
  mbps_pkg::cell_ctrl_t cell_ctrl [MAX_PATTERN];

  always_comb begin
    logic [mbps_pkg::LEN_W-1:0] pidx;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      pidx = len_m1 - mbps_pkg::LEN_W'(k);
      cell_ctrl[k].pattern = pattern_all[{pidx[3:0], 3'b000} +: 8];
      cell_ctrl[k].care    = (mbps_pkg::LEN_W'(k) < len_eff) && compare_mask[pidx[3:0]];
      cell_ctrl[k].anchor  = (len_eff != '0) && (mbps_pkg::LEN_W'(k) == len_m1);
    end
  end

  // The cell row: each cell passes its byte and flag to the next on a beat.
  logic [7:0]             cell_byte [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] cell_flag;
  logic [MAX_PATTERN-1:0] cell_ok;

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    logic [7:0] byte_in;
    logic       flag_in;
    if (k == 0) begin : g_head
      assign byte_in = byte_ch.data_byte;
      assign flag_in = (phase == '0);
    end else begin : g_link
      assign byte_in = cell_byte[k-1];
      assign flag_in = cell_flag[k-1];
    end
    mbps_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .shift   (byte_acc),
      .clear   (byte_ch.last_byte),
      .ctrl    (cell_ctrl[k]),
      .byte_in (byte_in),
      .flag_in (flag_in),
      .byte_q  (cell_byte[k]),
      .flag_q  (cell_flag[k]),
      .ok      (cell_ok[k])
    );
  end

  // Match decision: a nonempty pattern whose bytes all lie in this region.
  logic                   hit;
  logic [OFFSET_BITS-1:0] len_m1_ext;

  assign len_m1_ext = OFFSET_BITS'(len_m1[3:0]);
  assign hit = (len_eff != '0) && (offset >= len_m1_ext) && (&cell_ok);

  // Compare stage: hold one result per byte that yields a beat.
  logic                   s1_found;
  logic                   s1_done;
  logic [OFFSET_BITS-1:0] s1_start;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (byte_acc && (hit || byte_ch.last_byte)) begin
      s1_valid <= 1'b1;
    end else if (s1_take) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_acc) begin
      s1_found <= hit;
      s1_done  <= byte_ch.last_byte;
      s1_start <= offset - len_m1_ext;
    end
  end

  // Output register: add the region base and present the beat.
  logic                        out_found;
  logic                        out_done;
  logic [mbps_pkg::ADDR_W-1:0] out_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_take) begin
      out_valid <= 1'b1;
    end else if (match_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      out_found <= s1_found;
      out_done  <= s1_done;
      out_addr  <= s1_found ? region_base + mbps_pkg::ADDR_W'(s1_start) : '0;
    end
  end

  assign match_ch.valid         = out_valid;
  assign match_ch.found         = out_found;
  assign match_ch.match_address = out_addr;
  assign match_ch.region_done   = out_done;

  // Every beat sent carries a match or closes a region.
  a_beat_has_cause: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_found || out_done))
    else $error("result beat with neither match nor region end");

  // A waiting compare result holds while the output side is full.
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !out_free) |=> (s1_valid && $stable(s1_start) && $stable(s1_done)))
    else $error("compare stage changed under stall");

  // The last byte of a region returns position to the start.
  a_region_restart: assert property (@(posedge clk) disable iff (rst)
    (byte_acc && byte_ch.last_byte) |=> (offset == '0 && phase == '0))
    else $error("position not cleared after region end");

  // Within a region the offset never moves backward.
  a_offset_monotonic: assert property (@(posedge clk) disable iff (rst)
    (byte_acc && !byte_ch.last_byte) |=> (offset >= $past(offset)))
    else $error("offset decreased inside a region");

endmodule
